/* rtl/lpsc_pkg.sv */
// Shared widths, register codes, interface types and weight table for the steering controller.
package lpsc_pkg;

    localparam int RDG_W     = 10;
    localparam int WGT_W     = 17;
    localparam int PROD_W    = RDG_W + WGT_W + 1;
    localparam int WSUM_W    = PROD_W + 1;
    localparam int MAG_W     = WSUM_W - 1;
    localparam int TOT_W     = 14;
    localparam int Q_W       = 17;
    localparam int POS_W     = 17;
    localparam int ERR_W     = POS_W + 1;
    localparam int KP_W      = 16;
    localparam int MPROD_W   = KP_W + 1 + ERR_W;
    localparam int FRAC_W    = 12;
    localparam int CORR_W    = MPROD_W - FRAC_W;
    localparam int SUM_W     = CORR_W + 1;
    localparam int BASE_W    = 8;
    localparam int DRV_W     = 8;

    localparam int ARRAY_INPUTS = 8;
    localparam int LANE_COUNT   = ARRAY_INPUTS + 2;
    localparam int SIDE_R       = ARRAY_INPUTS;
    localparam int SIDE_L       = ARRAY_INPUTS + 1;

    localparam int LANE_STG  = 1;
    localparam int MERGE_STG = 4;
    localparam int DIV_STG   = Q_W + 1;
    localparam int CTRL_STG  = 4;
    localparam int PIPE_STG  = LANE_STG + MERGE_STG + DIV_STG + CTRL_STG;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_KP_GAIN        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INCLINE_OFFSET = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_BASE     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_BASE      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_WEIGHT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_WEIGHT    = 3'd5;

    localparam logic [KP_W-1:0]          RST_KP_GAIN        = 16'd246;
    localparam logic signed [WGT_W-1:0]  RST_INCLINE_OFFSET = '0;
    localparam logic [BASE_W-1:0]        RST_RIGHT_BASE     = 8'd120;
    localparam logic [BASE_W-1:0]        RST_LEFT_BASE      = 8'd120;
    localparam logic signed [WGT_W-1:0]  RST_RIGHT_WEIGHT   = -17'sd8000;
    localparam logic signed [WGT_W-1:0]  RST_LEFT_WEIGHT    = 17'sd8000;

    typedef struct packed {
        logic signed [WSUM_W-1:0] wsum;
        logic [TOT_W-1:0]         total;
    } merge_res_t;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           neg;
        logic           zero;
    } div_res_t;

    typedef struct packed {
        logic [KP_W-1:0]          kp_gain;
        logic signed [WGT_W-1:0]  incline_offset;
        logic [BASE_W-1:0]        right_base;
        logic [BASE_W-1:0]        left_base;
    } ctrl_cfg_t;

    typedef struct packed {
        logic [DRV_W-1:0]         right_drive;
        logic [DRV_W-1:0]         left_drive;
        logic signed [POS_W-1:0]  line_pos;
        logic                     no_line;
    } result_t;

    // Array sensor i sits at (i - 3.5) * 1000
    function automatic logic signed [WGT_W-1:0] array_weight(input int idx);
        return WGT_W'(idx * 1000 - 3500);
    endfunction

endpackage

/* rtl/lpsc_lane.sv */
// One centroid lane: reading times weight, registered with the reading itself.
module lpsc_lane (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [lpsc_pkg::RDG_W-1:0]         rdg,
    input  logic signed [lpsc_pkg::WGT_W-1:0]  weight,
    output logic signed [lpsc_pkg::PROD_W-1:0] prod,
    output logic [lpsc_pkg::RDG_W-1:0]         rdg_out
);
    import lpsc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [RDG_W-1:0]         rdg_reg;

    always_comb begin
        prod_next = $signed({1'b0, rdg}) * weight;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            rdg_reg  <= rdg;
        end
    end

    assign prod    = prod_reg;
    assign rdg_out = rdg_reg;

endmodule

/* rtl/lpsc_merge.sv */
// Registered adder tree that folds the lane products and readings into sum and total.
module lpsc_merge (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [lpsc_pkg::PROD_W-1:0] prod [lpsc_pkg::LANE_COUNT],
    input  logic [lpsc_pkg::RDG_W-1:0]         rdg  [lpsc_pkg::LANE_COUNT],
    output lpsc_pkg::merge_res_t               res
);
    import lpsc_pkg::*;

    localparam int L1 = (LANE_COUNT + 1) / 2;
    localparam int L2 = (L1 + 1) / 2;
    localparam int L3 = (L2 + 1) / 2;

    logic signed [WSUM_W-1:0] a1_reg [L1];
    logic signed [WSUM_W-1:0] a1_next [L1];
    logic [TOT_W-1:0]         t1_reg [L1];
    logic [TOT_W-1:0]         t1_next [L1];
    logic signed [WSUM_W-1:0] a2_reg [L2];
    logic signed [WSUM_W-1:0] a2_next [L2];
    logic [TOT_W-1:0]         t2_reg [L2];
    logic [TOT_W-1:0]         t2_next [L2];
    logic signed [WSUM_W-1:0] a3_reg [L3];
    logic signed [WSUM_W-1:0] a3_next [L3];
    logic [TOT_W-1:0]         t3_reg [L3];
    logic [TOT_W-1:0]         t3_next [L3];
    merge_res_t               res_reg;
    merge_res_t               res_next;

    always_comb begin
        for (int j = 0; j < L1; j++) begin
            a1_next[j] = WSUM_W'(prod[2*j]);
            t1_next[j] = TOT_W'(rdg[2*j]);
            if (2*j + 1 < LANE_COUNT) begin
                a1_next[j] = a1_next[j] + WSUM_W'(prod[2*j+1]);
                t1_next[j] = t1_next[j] + TOT_W'(rdg[2*j+1]);
            end
        end
        for (int j = 0; j < L2; j++) begin
            a2_next[j] = a1_reg[2*j];
            t2_next[j] = t1_reg[2*j];
            if (2*j + 1 < L1) begin
                a2_next[j] = a2_next[j] + a1_reg[2*j+1];
                t2_next[j] = t2_next[j] + t1_reg[2*j+1];
            end
        end
        for (int j = 0; j < L3; j++) begin
            a3_next[j] = a2_reg[2*j];
            t3_next[j] = t2_reg[2*j];
            if (2*j + 1 < L2) begin
                a3_next[j] = a3_next[j] + a2_reg[2*j+1];
                t3_next[j] = t3_next[j] + t2_reg[2*j+1];
            end
        end
        res_next.wsum  = a3_reg[0] + a3_reg[L3-1];
        res_next.total = t3_reg[0] + t3_reg[L3-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg  <= a1_next;
            t1_reg  <= t1_next;
            a2_reg  <= a2_next;
            t2_reg  <= t2_next;
            a3_reg  <= a3_next;
            t3_reg  <= t3_next;
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/lpsc_div.sv */
// Pipelined restoring divider: sum magnitude over total, one quotient bit per stage.
module lpsc_div (
    input  logic                 aclk,
    input  logic                 en,
    input  lpsc_pkg::merge_res_t mrg,
    output lpsc_pkg::div_res_t   res
);
    import lpsc_pkg::*;

    logic [TOT_W-1:0] rem_reg  [DIV_STG];
    logic [TOT_W-1:0] rem_next [DIV_STG];
    logic [Q_W-1:0]   low_reg  [DIV_STG];
    logic [Q_W-1:0]   low_next [DIV_STG];
    logic [TOT_W-1:0] d_reg    [DIV_STG];
    logic [TOT_W-1:0] d_next   [DIV_STG];
    logic [Q_W-1:0]   q_reg    [DIV_STG];
    logic [Q_W-1:0]   q_next   [DIV_STG];
    logic             neg_reg  [DIV_STG];
    logic             neg_next [DIV_STG];
    logic             zero_reg [DIV_STG];
    logic             zero_next[DIV_STG];

    logic signed [WSUM_W-1:0] mag_full;

    // Centroid of nonnegative readings stays inside the weight range, so the
    // quotient fits Q_W bits and the top dividend bits start below the divisor.
    always_comb begin
        mag_full      = mrg.wsum[WSUM_W-1] ? -mrg.wsum : mrg.wsum;
        rem_next[0]   = TOT_W'(mag_full[MAG_W-1:Q_W]);
        low_next[0]   = mag_full[Q_W-1:0];
        d_next[0]     = mrg.total;
        q_next[0]     = '0;
        neg_next[0]   = mrg.wsum[WSUM_W-1];
        zero_next[0]  = (mrg.total == '0);
    end

    for (genvar k = 1; k < DIV_STG; k++) begin : g_stage
        logic [TOT_W:0] trial;
        logic [TOT_W:0] diff;
        logic           ge;

        always_comb begin
            trial        = {rem_reg[k-1], low_reg[k-1][Q_W-1]};
            diff         = trial - {1'b0, d_reg[k-1]};
            ge           = (trial >= {1'b0, d_reg[k-1]});
            rem_next[k]  = ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
            low_next[k]  = {low_reg[k-1][Q_W-2:0], 1'b0};
            q_next[k]    = {q_reg[k-1][Q_W-2:0], ge};
            d_next[k]    = d_reg[k-1];
            neg_next[k]  = neg_reg[k-1];
            zero_next[k] = zero_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            d_reg    <= d_next;
            q_reg    <= q_next;
            neg_reg  <= neg_next;
            zero_reg <= zero_next;
        end
    end

    assign res.q    = q_reg[DIV_STG-1];
    assign res.neg  = neg_reg[DIV_STG-1];
    assign res.zero = zero_reg[DIV_STG-1];

endmodule

/* rtl/lpsc_ctrl.sv */
// Steering stages: position and error, gain multiply, truncation, drive clamp.
module lpsc_ctrl #(
    parameter int MAX_DRIVE = 250
) (
    input  logic                aclk,
    input  logic                en,
    input  lpsc_pkg::div_res_t  quo,
    input  lpsc_pkg::ctrl_cfg_t cfg,
    output lpsc_pkg::result_t   res
);
    import lpsc_pkg::*;

    localparam logic signed [SUM_W-1:0] MAX_S   = SUM_W'(MAX_DRIVE);
    localparam logic [DRV_W-1:0]        MAX_DRV = DRV_W'(MAX_DRIVE);

    logic signed [ERR_W-1:0]   pos_full;
    logic signed [POS_W-1:0]   pos1_reg, pos1_next;
    logic signed [ERR_W-1:0]   err1_reg, err1_next;
    logic                      zero1_reg;
    logic signed [MPROD_W-1:0] mprod2_reg, mprod2_next;
    logic signed [POS_W-1:0]   pos2_reg;
    logic                      zero2_reg;
    logic signed [MPROD_W-1:0] biased;
    logic signed [CORR_W-1:0]  corr3_reg, corr3_next;
    logic signed [POS_W-1:0]   pos3_reg;
    logic                      zero3_reg;
    logic signed [SUM_W-1:0]   rsum, lsum;
    result_t                   out_reg, out_next;

    function automatic logic [DRV_W-1:0] clamp_drive(input logic signed [SUM_W-1:0] v);
        logic [DRV_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > MAX_S) begin
            r = MAX_DRV;
        end else begin
            r = v[DRV_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        // An empty frame reads as position zero
        if (quo.zero) begin
            pos_full = '0;
        end else if (quo.neg) begin
            pos_full = -$signed({1'b0, quo.q});
        end else begin
            pos_full = $signed({1'b0, quo.q});
        end
        pos1_next   = pos_full[POS_W-1:0];
        err1_next   = pos_full - ERR_W'(cfg.incline_offset);

        mprod2_next = $signed({1'b0, cfg.kp_gain}) * err1_reg;

        // Round toward zero: bias negative products before the shift
        biased      = mprod2_reg + (mprod2_reg[MPROD_W-1] ?
                      MPROD_W'((1 << FRAC_W) - 1) : MPROD_W'(0));
        corr3_next  = CORR_W'(biased >>> FRAC_W);

        rsum = $signed(SUM_W'({1'b0, cfg.right_base})) + SUM_W'(corr3_reg);
        lsum = $signed(SUM_W'({1'b0, cfg.left_base})) - SUM_W'(corr3_reg);
        out_next.right_drive = clamp_drive(rsum);
        out_next.left_drive  = clamp_drive(lsum);
        out_next.line_pos    = pos3_reg;
        out_next.no_line     = zero3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos1_reg   <= pos1_next;
            err1_reg   <= err1_next;
            zero1_reg  <= quo.zero;
            mprod2_reg <= mprod2_next;
            pos2_reg   <= pos1_reg;
            zero2_reg  <= zero1_reg;
            corr3_reg  <= corr3_next;
            pos3_reg   <= pos2_reg;
            zero3_reg  <= zero2_reg;
            out_reg    <= out_next;
        end
    end

    assign res = out_reg;

endmodule

/* rtl/lpsc_obuf.sv */
// Two-word output buffer that decouples the pipeline from the result consumer.
module lpsc_obuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lpsc_pkg::result_t din,
    input  logic              m_ready,
    output logic              m_valid,
    output lpsc_pkg::result_t dout,
    output logic              full
);
    import lpsc_pkg::*;

    result_t     mem_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    always_comb begin
        pop       = (cnt_reg != 2'd0) && m_ready;
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= din;
        end
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign dout    = mem_reg[rptr_reg];
    assign full    = (cnt_reg == 2'd2);

endmodule

/* rtl/line_position_steering_controller_core.sv */
// Top level: config registers, sensor lanes, merge tree, divider, steering and output buffer.
//
// Line position steering controller. Each input word carries eight array
// readings and two side readings; the block returns one result word with the
// clamped right and left motor duties, the centroid line position and a
// no-line flag. One word is taken per clock while the output buffer has room.
// The word passes 28 register stages: one lane multiply stage, a four-level
// adder tree, an 18-stage restoring divider (a load stage, then one quotient
// bit per stage), four steering stages (position and error, gain multiply,
// truncation, clamp) and a two-word output buffer. The whole pipeline holds
// while the buffer is full and the consumer stalls.
// Registers sit on the APB port at byte offsets 0x00 kp_gain (Q4.12),
// 0x04 incline_offset, 0x08 right_base_speed, 0x0C left_base_speed,
// 0x10 right_side_weight, 0x14 left_side_weight; write them only while idle.
module line_position_steering_controller_core #(
    parameter int SENSOR_COUNT = 8,
    parameter int MAX_DRIVE    = 250
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lpsc_pkg::RDG_W-1:0]         s_refl_0,
    input  logic [lpsc_pkg::RDG_W-1:0]         s_refl_1,
    input  logic [lpsc_pkg::RDG_W-1:0]         s_refl_2,
    input  logic [lpsc_pkg::RDG_W-1:0]         s_refl_3,
    input  logic [lpsc_pkg::RDG_W-1:0]         s_refl_4,
    input  logic [lpsc_pkg::RDG_W-1:0]         s_refl_5,
    input  logic [lpsc_pkg::RDG_W-1:0]         s_refl_6,
    input  logic [lpsc_pkg::RDG_W-1:0]         s_refl_7,
    input  logic [lpsc_pkg::RDG_W-1:0]         s_right_side_reading,
    input  logic [lpsc_pkg::RDG_W-1:0]         s_left_side_reading,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lpsc_pkg::DRV_W-1:0]         m_right_drive,
    output logic [lpsc_pkg::DRV_W-1:0]         m_left_drive,
    output logic signed [lpsc_pkg::POS_W-1:0]  m_line_pos,
    output logic                               m_no_line,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lpsc_pkg::ADDR_W-1:0]        paddr,
    input  logic [lpsc_pkg::DATA_W-1:0]        pwdata,
    output logic [lpsc_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import lpsc_pkg::*;

    logic [KP_W-1:0]          kp_gain_reg;
    logic signed [WGT_W-1:0]  incline_offset_reg;
    logic [BASE_W-1:0]        right_base_reg;
    logic [BASE_W-1:0]        left_base_reg;
    logic signed [WGT_W-1:0]  right_weight_reg;
    logic signed [WGT_W-1:0]  left_weight_reg;
    logic [REG_IDX_W-1:0]     reg_idx;
    logic                     cfg_wr;

    logic [RDG_W-1:0]         rdg      [LANE_COUNT];
    logic signed [PROD_W-1:0] prod     [LANE_COUNT];
    logic [RDG_W-1:0]         lane_rdg [LANE_COUNT];
    merge_res_t               mrg;
    div_res_t                 quo;
    ctrl_cfg_t                ccfg;
    result_t                  pipe_out;
    result_t                  buf_out;

    logic                     adv;
    logic                     buf_full;
    logic [PIPE_STG-1:0]      vld_reg, vld_next;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_gain_reg        <= RST_KP_GAIN;
            incline_offset_reg <= RST_INCLINE_OFFSET;
            right_base_reg     <= RST_RIGHT_BASE;
            left_base_reg      <= RST_LEFT_BASE;
            right_weight_reg   <= RST_RIGHT_WEIGHT;
            left_weight_reg    <= RST_LEFT_WEIGHT;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_KP_GAIN:        kp_gain_reg        <= pwdata[KP_W-1:0];
                REG_INCLINE_OFFSET: incline_offset_reg <= pwdata[WGT_W-1:0];
                REG_RIGHT_BASE:     right_base_reg     <= pwdata[BASE_W-1:0];
                REG_LEFT_BASE:      left_base_reg      <= pwdata[BASE_W-1:0];
                REG_RIGHT_WEIGHT:   right_weight_reg   <= pwdata[WGT_W-1:0];
                REG_LEFT_WEIGHT:    left_weight_reg    <= pwdata[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KP_GAIN:        prdata = DATA_W'(kp_gain_reg);
            REG_INCLINE_OFFSET: prdata = DATA_W'(incline_offset_reg);
            REG_RIGHT_BASE:     prdata = DATA_W'(right_base_reg);
            REG_LEFT_BASE:      prdata = DATA_W'(left_base_reg);
            REG_RIGHT_WEIGHT:   prdata = DATA_W'(right_weight_reg);
            REG_LEFT_WEIGHT:    prdata = DATA_W'(left_weight_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Advance everything at once while the buffer can take a word
    assign adv     = !buf_full || m_ready;
    assign s_ready = adv;

    always_comb begin
        vld_next = adv ? {vld_reg[PIPE_STG-2:0], s_valid} : vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- lanes ----------------
    assign rdg[0]      = s_refl_0;
    assign rdg[1]      = s_refl_1;
    assign rdg[2]      = s_refl_2;
    assign rdg[3]      = s_refl_3;
    assign rdg[4]      = s_refl_4;
    assign rdg[5]      = s_refl_5;
    assign rdg[6]      = s_refl_6;
    assign rdg[7]      = s_refl_7;
    assign rdg[SIDE_R] = s_right_side_reading;
    assign rdg[SIDE_L] = s_left_side_reading;

    for (genvar i = 0; i < ARRAY_INPUTS; i++) begin : g_arr
        if (i < SENSOR_COUNT) begin : g_on
            lpsc_lane u_lane (
                .aclk    (aclk),
                .en      (adv),
                .rdg     (rdg[i]),
                .weight  (array_weight(i)),
                .prod    (prod[i]),
                .rdg_out (lane_rdg[i])
            );
        end else begin : g_off
            assign prod[i]     = '0;
            assign lane_rdg[i] = '0;
        end
    end

    lpsc_lane u_lane_right (
        .aclk    (aclk),
        .en      (adv),
        .rdg     (rdg[SIDE_R]),
        .weight  (right_weight_reg),
        .prod    (prod[SIDE_R]),
        .rdg_out (lane_rdg[SIDE_R])
    );

    lpsc_lane u_lane_left (
        .aclk    (aclk),
        .en      (adv),
        .rdg     (rdg[SIDE_L]),
        .weight  (left_weight_reg),
        .prod    (prod[SIDE_L]),
        .rdg_out (lane_rdg[SIDE_L])
    );

    // ---------------- merge, divide, steer ----------------
    lpsc_merge u_merge (
        .aclk (aclk),
        .en   (adv),
        .prod (prod),
        .rdg  (lane_rdg),
        .res  (mrg)
    );

    lpsc_div u_div (
        .aclk (aclk),
        .en   (adv),
        .mrg  (mrg),
        .res  (quo)
    );

    assign ccfg.kp_gain        = kp_gain_reg;
    assign ccfg.incline_offset = incline_offset_reg;
    assign ccfg.right_base     = right_base_reg;
    assign ccfg.left_base      = left_base_reg;

    lpsc_ctrl #(
        .MAX_DRIVE (MAX_DRIVE)
    ) u_ctrl (
        .aclk (aclk),
        .en   (adv),
        .quo  (quo),
        .cfg  (ccfg),
        .res  (pipe_out)
    );

    lpsc_obuf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (adv && vld_reg[PIPE_STG-1]),
        .din     (pipe_out),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .dout    (buf_out),
        .full    (buf_full)
    );

    assign m_right_drive = buf_out.right_drive;
    assign m_left_drive  = buf_out.left_drive;
    assign m_line_pos    = buf_out.line_pos;
    assign m_no_line     = buf_out.no_line;

`ifndef SYNTHESIS
    a_no_line_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_line) |-> (m_line_pos == '0))
        else $error("no_line word carries a nonzero position");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_right_drive <= DRV_W'(MAX_DRIVE)) &&
                     (m_left_drive <= DRV_W'(MAX_DRIVE))))
        else $error("drive word above MAX_DRIVE");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input held off without a stalled result");
`endif

endmodule
